// File: src/vgp_pkg.sv
package vgp_pkg;

  // Default sizes of the line parser
  localparam int MaxAlternatesDef = 8;
  localparam int MaxColumnsDef    = 65536;
  localparam int FirstSampleCol   = 9;
  localparam int QueueDepth       = 2;

  // Fixed field widths
  localparam int ByteW  = 8;
  localparam int ColW   = 16;
  localparam int PosW   = 32;
  localparam int CodeW  = 4;
  localparam int AccW   = 8;
  localparam int OutDataW = 56;

  // Column numbers with a meaning of their own
  localparam logic [ColW-1:0] PosColumn = 16'd1;
  localparam logic [ColW-1:0] RefColumn = 16'd3;
  localparam logic [ColW-1:0] AltColumn = 16'd4;

  // Special characters
  localparam logic [ByteW-1:0] ChTab     = 8'h09;
  localparam logic [ByteW-1:0] ChNewline = 8'h0A;
  localparam logic [ByteW-1:0] ChNul     = 8'h00;
  localparam logic [ByteW-1:0] ChComma   = 8'h2C;
  localparam logic [ByteW-1:0] ChZero    = 8'h30;
  localparam logic [ByteW-1:0] ChNine    = 8'h39;

  localparam logic [CodeW-1:0] CodeOther = 4'hF;

  // Kind of a byte as seen by the back end
  typedef enum logic [1:0] {
    KIND_END  = 2'd0,
    KIND_TAB  = 2'd1,
    KIND_CHAR = 2'd2
  } byte_kind_t;

  // Classified byte handed from the front end to the back end
  typedef struct packed {
    byte_kind_t       kind;
    logic             is_digit;
    logic [3:0]       digit;
    logic [CodeW-1:0] base;
    logic             is_comma;
  } byte_class_t;

  // One-hot nucleotide code of a character; any other character gives CodeOther
  function automatic logic [CodeW-1:0] base_code(input logic [ByteW-1:0] c);
    logic [CodeW-1:0] code;
    unique case (c)
      8'h41, 8'h61: code = 4'd1;
      8'h43, 8'h63: code = 4'd2;
      8'h47, 8'h67: code = 4'd4;
      8'h54, 8'h74: code = 4'd8;
      default:      code = CodeOther;
    endcase
    return code;
  endfunction

endpackage

// File: src/vgp_front.sv
module vgp_front
  import vgp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [ByteW-1:0]   in_tdata,
  output logic               q_valid,
  input  logic               q_pop,
  output byte_class_t        q_item
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  byte_class_t            cls;
  byte_class_t            queue_r [QueueDepth];
  logic [PtrW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]        count_r, count_nxt;
  logic                   push;
  logic                   pop;

  // Classify the incoming byte
  always_comb begin
    cls.is_digit = (in_tdata >= ChZero) && (in_tdata <= ChNine);
    cls.digit    = 4'(in_tdata - ChZero);
    cls.base     = base_code(in_tdata);
    cls.is_comma = (in_tdata == ChComma);
    if ((in_tdata == ChNewline) || (in_tdata == ChNul)) begin
      cls.kind = KIND_END;
    end else if (in_tdata == ChTab) begin
      cls.kind = KIND_TAB;
    end else begin
      cls.kind = KIND_CHAR;
    end
  end

  assign in_tready = (count_r != CntW'(QueueDepth));
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;
  assign q_valid   = (count_r != '0);
  assign q_item    = queue_r[rd_ptr_r];

  // Queue pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: src/vgp_back.sv
module vgp_back
  import vgp_pkg::*;
#(
  parameter int MAX_ALTERNATES = MaxAlternatesDef,
  parameter int MAX_COLUMNS    = MaxColumnsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  byte_class_t          q_item,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OutDataW-1:0]  out_tdata
);

  localparam int CntW    = $clog2(MAX_ALTERNATES + 1);
  localparam int AIdxW   = (MAX_ALTERNATES > 1) ? $clog2(MAX_ALTERNATES) : 1;
  localparam int ColLim  = (MAX_COLUMNS - 1 < 65535) ? MAX_COLUMNS - 1 : 65535;

  logic [ColW-1:0]   col_r, col_nxt;
  logic [1:0]        cif_r, cif_nxt;
  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [CodeW-1:0]  ref_r, ref_nxt;
  logic [CntW-1:0]   alt_cnt_r, alt_cnt_nxt;
  logic [AccW-1:0]   acc_r, acc_nxt;
  logic              done_r, done_nxt;
  logic              miss_r, miss_nxt;
  logic [CodeW-1:0]  alt_tab_r [MAX_ALTERNATES];
  logic              alt_wr;

  logic              pop;
  logic              emit;
  logic [CodeW-1:0]  code;
  logic [AIdxW-1:0]  rd_idx;
  logic [PosW+3:0]   pos_sum;
  logic [11:0]       acc_sum;

  logic              out_valid_r;
  logic [OutDataW-1:0] out_data_r;

  assign pop   = q_valid && (!out_valid_r || out_tready);
  assign q_pop = pop;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Result of a sample field that ends with this byte
  assign rd_idx = AIdxW'(acc_r - 8'd1);
  always_comb begin
    emit = 1'b0;
    code = CodeOther;
    if ((q_item.kind != KIND_CHAR) && (col_r >= ColW'(FirstSampleCol))) begin
      if ((cif_r == 2'd0) || miss_r) begin
        emit = 1'b1;
      end else if (acc_r > AccW'(alt_cnt_r)) begin
        emit = 1'b1;
      end else if (acc_r != '0) begin
        emit = 1'b1;
        code = alt_tab_r[rd_idx];
      end
    end
  end

  // Saturating decimal accumulations
  assign pos_sum = ({4'd0, pos_r} << 3) + ({4'd0, pos_r} << 1) + (PosW+4)'(q_item.digit);
  assign acc_sum = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + 12'(q_item.digit);

  // Line and field state update
  always_comb begin
    col_nxt     = col_r;
    cif_nxt     = cif_r;
    pos_nxt     = pos_r;
    ref_nxt     = ref_r;
    alt_cnt_nxt = alt_cnt_r;
    acc_nxt     = acc_r;
    done_nxt    = done_r;
    miss_nxt    = miss_r;
    alt_wr      = 1'b0;
    unique case (q_item.kind)
      KIND_END: begin
        col_nxt     = '0;
        pos_nxt     = '0;
        ref_nxt     = '0;
        alt_cnt_nxt = '0;
        cif_nxt     = '0;
        acc_nxt     = '0;
        done_nxt    = 1'b0;
        miss_nxt    = 1'b0;
      end
      KIND_TAB: begin
        if (col_r < ColW'(ColLim)) begin
          col_nxt = col_r + 1'b1;
        end
        cif_nxt  = '0;
        acc_nxt  = '0;
        done_nxt = 1'b0;
        miss_nxt = 1'b0;
      end
      default: begin
        if (col_r == PosColumn) begin
          if (q_item.is_digit) begin
            pos_nxt = (pos_sum > {4'd0, {PosW{1'b1}}}) ? {PosW{1'b1}} : pos_sum[PosW-1:0];
          end
        end else if (col_r == RefColumn) begin
          if (cif_r == 2'd0) begin
            ref_nxt = q_item.base;
          end
        end else if (col_r == AltColumn) begin
          if (!q_item.is_comma && (alt_cnt_r < CntW'(MAX_ALTERNATES))) begin
            alt_wr      = 1'b1;
            alt_cnt_nxt = alt_cnt_r + 1'b1;
          end
        end else if (col_r >= ColW'(FirstSampleCol)) begin
          if (cif_r == 2'd0) begin
            if (q_item.is_digit) begin
              acc_nxt = AccW'(q_item.digit);
            end else begin
              miss_nxt = 1'b1;
              done_nxt = 1'b1;
            end
          end else if (!done_r) begin
            if (q_item.is_digit) begin
              acc_nxt = (acc_sum > 12'd255) ? 8'd255 : acc_sum[AccW-1:0];
            end else begin
              done_nxt = 1'b1;
            end
          end
        end
        if (cif_r != 2'd3) begin
          cif_nxt = cif_r + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      cif_r     <= '0;
      pos_r     <= '0;
      ref_r     <= '0;
      alt_cnt_r <= '0;
      acc_r     <= '0;
      done_r    <= 1'b0;
      miss_r    <= 1'b0;
    end else if (pop) begin
      col_r     <= col_nxt;
      cif_r     <= cif_nxt;
      pos_r     <= pos_nxt;
      ref_r     <= ref_nxt;
      alt_cnt_r <= alt_cnt_nxt;
      acc_r     <= acc_nxt;
      done_r    <= done_nxt;
      miss_r    <= miss_nxt;
    end
  end

  // Alternate allele table, written in ALT column order
  always_ff @(posedge clk) begin
    if (pop && alt_wr) begin
      alt_tab_r[alt_cnt_r[AIdxW-1:0]] <= q_item.base;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data_r <= {code, ref_r, pos_r, col_r};
    end
  end

endmodule

// File: src/vcf_genotype_line_parser.sv
// Path: the byte that ends a sample field is written into the queue when it is accepted,
// and its result transaction is offered from the output register once the back end pops it.
// Throughput: one byte per cycle unless stalled, set by the back end's single state update.
// Reset: synchronous, active low; clears the queue, the output register and all line
// state. The alternate table is not cleared, as each line writes it before reading.
module vcf_genotype_line_parser
  import vgp_pkg::*;
#(
  parameter int MAX_ALTERNATES = MaxAlternatesDef,
  parameter int MAX_COLUMNS    = MaxColumnsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [ByteW-1:0]     in_tdata,   // [7:0] text_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [15:0] sample_column, [47:16] genome_position,
  // [51:48] reference_code, [55:52] allele_code
  output logic [OutDataW-1:0]  out_tdata
);

  logic        q_valid;
  logic        q_pop;
  byte_class_t q_item;

  // Byte classification and queue
  vgp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  // Field tracking and result generation
  vgp_back #(
    .MAX_ALTERNATES (MAX_ALTERNATES),
    .MAX_COLUMNS    (MAX_COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: tb/vcf_genotype_line_parser_tb.sv
module vcf_genotype_line_parser_tb;
  import vgp_pkg::*;

  localparam int ColLimit     = (MaxColumnsDef - 1 < 65535) ? MaxColumnsDef - 1 : 65535;
  localparam int CycleLimit   = 3_000_000;
  localparam int DrainCycles  = 12;
  localparam int PhaseBytes   = 330;
  localparam int HoldCycles   = 400;

  // One genotype call, laid out as on out_tdata.
  typedef struct packed {
    logic [CodeW-1:0] allele;
    logic [CodeW-1:0] ref_base;
    logic [PosW-1:0]  pos;
    logic [ColW-1:0]  col;
  } genotype_call_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  // Text waiting to be sent and genotype calls waiting to be seen.
  logic [ByteW-1:0] text_q[$];
  genotype_call_t   call_q[$];

  int  bytes_queued   = 0;
  int  bytes_accepted = 0;
  int  calls_checked  = 0;
  int  stall_cycles   = 0;
  int  errors         = 0;
  int  cycles         = 0;
  int  send_idle_pct  = 27;
  int  recv_idle_pct  = 80;
  int  phase          = 1;
  int  hold_left      = 0;
  bit  hold_done      = 1'b0;
  bit  in_taken       = 1'b0;

  // Line state of the parser as the testbench sees it.
  logic [ColW-1:0]  col_idx   = '0;
  logic [1:0]       chars     = '0;
  logic [PosW-1:0]  pos_acc   = '0;
  logic [CodeW-1:0] ref_code  = '0;
  logic [CodeW-1:0] alt_tab[MaxAlternatesDef];
  logic [3:0]       alt_cnt   = '0;
  logic [AccW-1:0]  gt_idx    = '0;
  bit               gt_done   = 1'b0;
  bit               gt_missing = 1'b0;

  vcf_genotype_line_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [CodeW-1:0] nucleotide_code(input logic [ByteW-1:0] b);
    case (b)
      "A", "a": return 4'd1;
      "C", "c": return 4'd2;
      "G", "g": return 4'd4;
      "T", "t": return 4'd8;
      default:  return CodeOther;
    endcase
  endfunction

  function automatic bit is_numeral(input logic [ByteW-1:0] b);
    return b >= ChZero && b <= ChNine;
  endfunction

  task automatic clear_field_state();
    chars      = '0;
    gt_idx     = '0;
    gt_done    = 1'b0;
    gt_missing = 1'b0;
  endtask

  // Decides the call of a sample field that has just ended; returns 0 when there is none.
  function automatic bit close_sample(output genotype_call_t c);
    logic [CodeW-1:0] code;
    c = '0;
    if (col_idx < FirstSampleCol) return 1'b0;
    if (chars == 2'd0 || gt_missing) begin
      code = CodeOther;
    end else if (gt_idx > alt_cnt) begin
      code = CodeOther;
    end else if (gt_idx == '0) begin
      return 1'b0;
    end else begin
      code = alt_tab[gt_idx - 8'd1];
    end
    c.col      = col_idx;
    c.pos      = pos_acc;
    c.ref_base = ref_code;
    c.allele   = code;
    return 1'b1;
  endfunction

  // Advances the line state by one text byte and records any call it completes.
  task automatic parse_byte(input logic [ByteW-1:0] b);
    genotype_call_t c;
    logic [35:0]    p;
    logic [11:0]    a;
    if (b == ChNewline || b == ChNul) begin
      if (close_sample(c)) call_q.insert(call_q.size(), c);
      col_idx  = '0;
      pos_acc  = '0;
      ref_code = '0;
      alt_cnt  = '0;
      clear_field_state();
    end else if (b == ChTab) begin
      if (close_sample(c)) call_q.insert(call_q.size(), c);
      if (col_idx < ColLimit) col_idx = col_idx + 1'b1;
      clear_field_state();
    end else begin
      if (col_idx == PosColumn) begin
        if (is_numeral(b)) begin
          p = {4'b0, pos_acc} * 36'd10 + 36'(b - ChZero);
          pos_acc = (p > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
        end
      end else if (col_idx == RefColumn) begin
        if (chars == 2'd0) ref_code = nucleotide_code(b);
      end else if (col_idx == AltColumn) begin
        if (b != ChComma && alt_cnt < MaxAlternatesDef) begin
          alt_tab[alt_cnt] = nucleotide_code(b);
          alt_cnt = alt_cnt + 1'b1;
        end
      end else if (col_idx >= FirstSampleCol) begin
        if (chars == 2'd0) begin
          if (is_numeral(b)) begin
            gt_idx = 8'(b - ChZero);
          end else begin
            gt_missing = 1'b1;
            gt_done    = 1'b1;
          end
        end else if (!gt_done) begin
          if (is_numeral(b)) begin
            a = {4'b0, gt_idx} * 12'd10 + 12'(b - ChZero);
            gt_idx = (a > 12'd255) ? 8'd255 : a[7:0];
          end else begin
            gt_done = 1'b1;
          end
        end
      end
      if (chars < 2'd3) chars = chars + 1'b1;
    end
  endtask

  task automatic push_byte(input logic [ByteW-1:0] b);
    text_q.insert(text_q.size(), b);
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s.getc(i));
  endtask

  // Any byte that neither separates fields nor ends the line.
  function automatic logic [ByteW-1:0] plain_byte();
    logic [ByteW-1:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == ChTab || b == ChNewline) b = 8'h7E;
    return b;
  endfunction

  // A base letter most of the time, occasionally some other byte.
  function automatic logic [ByteW-1:0] base_byte();
    string letters;
    letters = "ACGTacgtN";
    if ($urandom_range(0, 9) == 0) return plain_byte();
    return letters.getc($urandom_range(0, letters.len() - 1));
  endfunction

  task automatic push_line_end();
    push_byte(($urandom_range(0, 9) == 0) ? ChNul : ChNewline);
  endtask

  // A data line with the usual column layout and random content.
  task automatic push_data_line();
    int n_digits;
    int n_alt;
    int alts_kept;
    int n_samples;
    int v;
    push_text("chr");
    push_byte(plain_byte());
    push_byte(ChTab);
    n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 9);
    repeat (n_digits) begin
      if ($urandom_range(0, 15) == 0) push_byte(plain_byte());
      push_byte(ChZero + 8'($urandom_range(0, 9)));
    end
    push_text("\t.\t");
    repeat (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3)) push_byte(base_byte());
    push_byte(ChTab);
    n_alt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 11) : $urandom_range(1, 4);
    for (int i = 0; i < n_alt; i++) begin
      if (i > 0 && $urandom_range(0, 2) != 0) push_byte(ChComma);
      push_byte(base_byte());
    end
    alts_kept = (n_alt < MaxAlternatesDef) ? n_alt : MaxAlternatesDef;
    push_text("\t50\tPASS\tDP=");
    push_byte(plain_byte());
    push_text("\tGT");
    n_samples = $urandom_range(1, 8);
    repeat (n_samples) begin
      push_byte(ChTab);
      case ($urandom_range(0, 19))
        0: ;
        1: push_text(($urandom_range(0, 1) != 0) ? "./." : ".");
        2: push_text($sformatf("%0d", alts_kept + $urandom_range(1, 20)));
        3: push_text($sformatf("%0d", $urandom_range(256, 99999)));
        4: push_byte(plain_byte());
        default: begin
          v = (alts_kept == 0) ? 0 : $urandom_range(0, alts_kept);
          if ($urandom_range(0, 3) == 0) push_byte(ChZero);
          push_text($sformatf("%0d", v));
          case ($urandom_range(0, 3))
            0: push_text($sformatf("|%0d", $urandom_range(0, 9)));
            1: push_text($sformatf("/%0d", $urandom_range(0, 9)));
            2: begin
              push_text(":");
              push_byte(plain_byte());
            end
            default: ;
          endcase
        end
      endcase
    end
    push_line_end();
  endtask

  // Empty lines, lines cut short before the samples and raw byte noise.
  task automatic push_broken_line();
    case ($urandom_range(0, 2))
      0: push_line_end();
      1: begin
        repeat ($urandom_range(1, 8)) begin
          push_text(($urandom_range(0, 1) != 0) ? "12" : "A");
          push_byte(ChTab);
        end
        push_line_end();
      end
      default: begin
        repeat ($urandom_range(5, 40)) push_byte(8'($urandom_range(0, 255)));
        push_byte(ChNewline);
      end
    endcase
  endtask

  task automatic push_random_lines(input int budget);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      if ($urandom_range(0, 4) == 0) push_broken_line();
      else push_data_line();
    end
  endtask

  // Waits until every queued byte has gone through a transaction.
  task automatic wait_sent();
    while (bytes_accepted != bytes_queued) @(posedge clk);
  endtask

  // Sender: holds a byte until it is taken, then offers the next one or idles.
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (rst_n && text_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= text_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // Receiver: random back-pressure, and one long hold-off early in the last phase.
  always @(negedge clk) begin
    if (phase == 3 && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: feeds accepted bytes to the line state and checks every call transaction.
  always @(posedge clk) begin : monitor
    genotype_call_t got;
    genotype_call_t want;
    cycles++;
    if (rst_n && in_tvalid && in_tready) begin
      parse_byte(in_tdata);
      bytes_accepted++;
      in_taken = 1'b1;
    end
    if (rst_n && in_tvalid && !in_tready) stall_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (call_q.size() == 0) begin
        $error("genotype call with none pending: %h", out_tdata);
        errors++;
      end else begin
        want = call_q.pop_front();
        calls_checked++;
        if (got.col !== want.col) begin
          $error("sample_column: expected %0d, got %0d", want.col, got.col);
          errors++;
        end
        if (got.pos !== want.pos) begin
          $error("genome_position: expected %0d, got %0d", want.pos, got.pos);
          errors++;
        end
        if (got.ref_base !== want.ref_base) begin
          $error("reference_code: expected %h, got %h", want.ref_base, got.ref_base);
          errors++;
        end
        if (got.allele !== want.allele) begin
          $error("allele_code: expected %h, got %h", want.allele, got.allele);
          errors++;
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    while (cycles < CycleLimit) @(posedge clk);
    $display("vcf_genotype_line_parser_tb: done, errors");
    $finish;
  end

  initial begin
    for (int i = 0; i < MaxAlternatesDef; i++) alt_tab[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed lines: empty lines, a line ending early, saturation and the odd genotypes.
    push_byte(ChNewline);
    push_byte(ChNul);
    push_text("c1\t12\n");
    push_text("c1\t1x2\t.\tg\tACGTACGTac\t.\t.\t.\tGT\t8\t10\t1/1\t0\t999\t.\t\n");
    push_text("c2\t99999999999\t.\tN\tC,G\t.\t.\t.\tGT\t2|0\t3\n");
    push_byte(8'hFF);
    push_text("\t5\t.\t\tT\t.\t.\t.\tGT\t1");
    push_byte(ChNul);

    push_random_lines(PhaseBytes);
    wait_sent();

    phase = 2;
    send_idle_pct = 80;
    recv_idle_pct = 27;
    push_random_lines(PhaseBytes);
    wait_sent();

    phase = 3;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_lines(PhaseBytes);
    wait_sent();

    while (call_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d text bytes over three back-pressure phases; checked %0d genotype calls.",
             bytes_accepted, calls_checked);
    $display("The parser held back its input for %0d cycles in all.", stall_cycles);
    if (errors == 0 && call_q.size() == 0) begin
      $display("vcf_genotype_line_parser_tb: done, clean");
    end else begin
      $display("vcf_genotype_line_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
